@@ sv/byte_range_header_parser_macros.svh @@
// ---------------------------------------------------------------------------
// Byte range header parser assertion macros
// Shared concurrent assertion forms for the parser's checker.
// ---------------------------------------------------------------------------
`ifndef BYTE_RANGE_HEADER_PARSER_MACROS_SVH
`define BYTE_RANGE_HEADER_PARSER_MACROS_SVH

// Checked on every rising edge outside reset.
`define BRHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BRHP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/brhp_pkg.sv @@
// ---------------------------------------------------------------------------
// Byte range header parser package
// Widths, character codes and parse phases shared by the parser files.
// ---------------------------------------------------------------------------
`default_nettype none

package brhp_pkg;

    localparam int LEN_BITS = 48;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DASH = 8'h2d;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    typedef enum logic [1:0] {
        PH_PREFIX,
        PH_FIRST,
        PH_START,
        PH_END
    } phase_t;

    // Characters of the unit prefix "bytes=".
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h62;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h65;
            3'd4:    c = 8'h73;
            3'd5:    c = 8'h3d;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/byte_range_header_parser.sv @@
// ---------------------------------------------------------------------------
// Byte range header parser
// Parses a single "bytes=first-last" range header value, one character per
// item, and reports the resulting byte range or the whole object.
// ---------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | header_char, is_last
//  config   | config_we            | config_data (object length)
//  output   | out_valid / out_stall| range_accepted, first_byte, last_byte,
//           |                      | part_length
//
//  One character is taken every cycle while in_stall is low; the multiply-by-ten
//  accumulator updates in the cycle of acceptance.
//  After its last character is accepted, a result passes the evaluation, range
//  selection and length registers in turn; an output stall can hold it in any.
//  Reset clears the parse state, the pipeline valid flags and the object length.
//  A stalled output holds its result; the input stalls once all three hold one.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_range_header_parser
    import brhp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          header_char,
    input  logic                is_last,
    input  logic                config_we,
    input  logic [LEN_BITS-1:0] config_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                range_accepted,
    output logic [LEN_BITS-1:0] first_byte,
    output logic [LEN_BITS-1:0] last_byte,
    output logic [LEN_BITS-1:0] part_length
);

    logic [LEN_BITS-1:0] len_reg;
    logic [LEN_BITS-1:0] len_m1_reg;
    logic                len_zero_reg;

    phase_t              phase_reg, phase_next;
    logic [2:0]          prefix_idx_reg, prefix_idx_next;
    logic                rejected_reg, rejected_next;
    logic [LEN_BITS-1:0] start_reg, start_next;
    logic [LEN_BITS-1:0] end_reg, end_next;
    logic                saw_start_reg, saw_start_next;
    logic                saw_end_reg, saw_end_next;
    logic                end_sat_reg, end_sat_next;

    logic                is_digit;
    logic [3:0]          digit_val;
    logic [LEN_BITS-1:0] acc_in;
    logic [LEN_BITS+3:0] acc_wide;
    logic                acc_sat;
    logic [LEN_BITS-1:0] acc_value;

    logic                in_accept;
    logic                ready_e, ready_a, ready_o;

    logic                e_valid_reg;
    logic                e_bad_reg;
    logic [LEN_BITS-1:0] e_start_reg;
    logic [LEN_BITS-1:0] e_end_reg;
    logic                e_saw_start_reg;
    logic                e_saw_end_reg;
    logic                e_sat_reg;

    logic                a_valid_reg;
    logic                a_ok_reg;
    logic [LEN_BITS-1:0] a_lo_reg;
    logic [LEN_BITS-1:0] a_hi_reg;

    logic                start_lt_len;
    logic                end_ge_len;
    logic [LEN_BITS-1:0] len_minus_end;
    logic                a_ok_next;
    logic [LEN_BITS-1:0] a_lo_next;
    logic [LEN_BITS-1:0] a_hi_next;

    logic                lo_gt_hi;
    logic [LEN_BITS-1:0] span;

    logic                out_valid_reg;
    logic                range_accepted_reg;
    logic [LEN_BITS-1:0] first_byte_reg;
    logic [LEN_BITS-1:0] last_byte_reg;
    logic [LEN_BITS-1:0] part_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            len_m1_reg   <= '1;
            len_zero_reg <= 1'b1;
        end
        else if (config_we)
        begin
            len_reg      <= config_data;
            len_m1_reg   <= config_data - LEN_BITS'(1);
            len_zero_reg <= (config_data == '0);
        end
    end

    assign ready_o   = !out_valid_reg || !out_stall;
    assign ready_a   = !a_valid_reg || ready_o;
    assign ready_e   = !e_valid_reg || ready_a;
    assign in_stall  = !ready_e;
    assign in_accept = in_valid && ready_e;

    assign is_digit  = (header_char >= CHAR_ZERO) && (header_char <= CHAR_NINE);
    assign digit_val = header_char[3:0];
    assign acc_in    = (phase_reg == PH_END) ? end_reg : start_reg;
    assign acc_wide  = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                     + {LEN_BITS'(0), digit_val};
    assign acc_sat   = |acc_wide[LEN_BITS+3:LEN_BITS];
    assign acc_value = acc_sat ? '1 : acc_wide[LEN_BITS-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        prefix_idx_next = prefix_idx_reg;
        rejected_next   = rejected_reg;
        if (!rejected_reg)
        begin
            unique case (phase_reg)
                PH_PREFIX:
                begin
                    if (prefix_idx_reg < PREFIX_LEN
                        && header_char == prefix_char(prefix_idx_reg))
                    begin
                        prefix_idx_next = prefix_idx_reg + 3'd1;
                        if (prefix_idx_next == PREFIX_LEN)
                        begin
                            phase_next = PH_FIRST;
                        end
                    end
                    else
                    begin
                        rejected_next = 1'b1;
                    end
                end
                PH_FIRST, PH_START:
                begin
                    if (is_digit)
                    begin
                        phase_next = PH_START;
                    end
                    else if (header_char == CHAR_DASH)
                    begin
                        phase_next = PH_END;
                    end
                    else
                    begin
                        rejected_next = 1'b1;
                    end
                end
                PH_END:
                begin
                    if (!is_digit)
                    begin
                        rejected_next = 1'b1;
                    end
                end
                default:
                begin
                    rejected_next = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        start_next     = start_reg;
        end_next       = end_reg;
        saw_start_next = saw_start_reg;
        saw_end_next   = saw_end_reg;
        end_sat_next   = end_sat_reg;
        if (!rejected_reg && is_digit)
        begin
            if (phase_reg == PH_FIRST || phase_reg == PH_START)
            begin
                start_next     = acc_value;
                saw_start_next = 1'b1;
            end
            else if (phase_reg == PH_END)
            begin
                end_next     = acc_value;
                saw_end_next = 1'b1;
                end_sat_next = end_sat_reg | acc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PREFIX;
            prefix_idx_reg <= '0;
            rejected_reg   <= 1'b0;
            start_reg      <= '0;
            end_reg        <= '0;
            saw_start_reg  <= 1'b0;
            saw_end_reg    <= 1'b0;
            end_sat_reg    <= 1'b0;
        end
        else if (in_accept)
        begin
            if (is_last)
            begin
                phase_reg      <= PH_PREFIX;
                prefix_idx_reg <= '0;
                rejected_reg   <= 1'b0;
                start_reg      <= '0;
                end_reg        <= '0;
                saw_start_reg  <= 1'b0;
                saw_end_reg    <= 1'b0;
                end_sat_reg    <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                prefix_idx_reg <= prefix_idx_next;
                rejected_reg   <= rejected_next;
                start_reg      <= start_next;
                end_reg        <= end_next;
                saw_start_reg  <= saw_start_next;
                saw_end_reg    <= saw_end_next;
                end_sat_reg    <= end_sat_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (ready_e)
        begin
            e_valid_reg <= in_accept && is_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_last)
        begin
            e_bad_reg       <= rejected_next || (phase_next != PH_END);
            e_start_reg     <= start_next;
            e_end_reg       <= end_next;
            e_saw_start_reg <= saw_start_next;
            e_saw_end_reg   <= saw_end_next;
            e_sat_reg       <= end_sat_next;
        end
    end

    assign start_lt_len  = e_start_reg < len_reg;
    assign end_ge_len    = e_end_reg >= len_reg;
    assign len_minus_end = len_reg - e_end_reg;

    always_comb
    begin
        a_ok_next = !e_bad_reg && start_lt_len;
        a_lo_next = e_start_reg;
        a_hi_next = len_m1_reg;
        if (e_saw_end_reg)
        begin
            if (!e_saw_start_reg)
            begin
                a_lo_next = (e_sat_reg || end_ge_len) ? '0 : len_minus_end;
            end
            else if (!end_ge_len)
            begin
                a_hi_next = e_end_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (ready_a)
        begin
            a_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_valid_reg && ready_a)
        begin
            a_ok_reg <= a_ok_next;
            a_lo_reg <= a_lo_next;
            a_hi_reg <= a_hi_next;
        end
    end

    assign lo_gt_hi = a_lo_reg > a_hi_reg;
    assign span     = a_hi_reg - a_lo_reg + LEN_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready_o)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && ready_o)
        begin
            if (a_ok_reg && !lo_gt_hi)
            begin
                range_accepted_reg <= 1'b1;
                first_byte_reg     <= a_lo_reg;
                last_byte_reg      <= a_hi_reg;
                part_length_reg    <= span;
            end
            else
            begin
                range_accepted_reg <= 1'b0;
                first_byte_reg     <= '0;
                last_byte_reg      <= len_zero_reg ? '0 : len_m1_reg;
                part_length_reg    <= len_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign range_accepted = range_accepted_reg;
    assign first_byte     = first_byte_reg;
    assign last_byte      = last_byte_reg;
    assign part_length    = part_length_reg;

endmodule

`default_nettype wire

@@ sv/brhp_checker.sv @@
// ---------------------------------------------------------------------------
// Byte range header parser checker
// Port-level assertions on the results of the parser, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "byte_range_header_parser_macros.svh"

module brhp_checker
    import brhp_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire logic                range_accepted,
    input wire logic [LEN_BITS-1:0] first_byte,
    input wire logic [LEN_BITS-1:0] last_byte,
    input wire logic [LEN_BITS-1:0] part_length
);

    // An accepted range is ordered and its length matches its bounds.
    `BRHP_ASSERT(a_range_consistent, out_valid && range_accepted |-> last_byte >= first_byte && part_length == last_byte - first_byte + LEN_BITS'(1), "accepted range is inconsistent")

    // A rejection reports the whole object from byte zero.
    `BRHP_ASSERT(a_reject_whole, out_valid && !range_accepted |-> first_byte == '0 && (part_length == last_byte + LEN_BITS'(1) || (part_length == '0 && last_byte == '0)), "rejection does not cover the object")

    // A stalled result is held.
    `BRHP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(range_accepted) && $stable(first_byte) && $stable(last_byte) && $stable(part_length), "stalled result changed")

    // No result is shown during or just after reset.
    `BRHP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind byte_range_header_parser brhp_checker u_brhp_checker (.*);

`default_nettype wire

@@ tb/byte_range_header_parser_checker.sv @@
// ---------------------------------------------------------------------------
// Byte range header parser checker
// Watches the character, configuration and result channels of the parser.
// It keeps its own model of the parse and of the object length, works out
// the range that each completed header should give, and compares every
// accepted result with the oldest one still waiting.
// ---------------------------------------------------------------------------
module byte_range_header_parser_checker
    import brhp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [7:0]          header_char,
    input  logic                is_last,
    input  logic                config_we,
    input  logic [LEN_BITS-1:0] config_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic                range_accepted,
    input  logic [LEN_BITS-1:0] first_byte,
    input  logic [LEN_BITS-1:0] last_byte,
    input  logic [LEN_BITS-1:0] part_length,
    output int                  fail_count,
    output int                  pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
    localparam logic [47:0] UNIT_WORD = "bytes=";

    typedef struct packed {
        logic                accepted;
        logic [LEN_BITS-1:0] start_pos;
        logic [LEN_BITS-1:0] end_pos;
        logic [LEN_BITS-1:0] span;
    } byte_range_t;

    phase_t      phase;
    int unsigned match_pos;
    logic [63:0] start_acc;
    logic [63:0] end_acc;
    logic [63:0] obj_len;
    logic        has_start;
    logic        has_end;
    logic        end_sat;
    logic        bad;
    byte_range_t expected_ranges[$];

    task automatic clear_parse();
        phase     = PH_PREFIX;
        match_pos = 0;
        start_acc = '0;
        end_acc   = '0;
        has_start = 1'b0;
        has_end   = 1'b0;
        end_sat   = 1'b0;
        bad       = 1'b0;
    endtask

    function automatic logic [63:0] decimal_step(input logic [63:0] v, input logic [7:0] c,
                                                 inout logic sat);
        logic [63:0] d;
        d = 64'(c - CHAR_ZERO);
        if (v > (LEN_MAX - d) / 64'd10)
        begin
            sat = 1'b1;
            return LEN_MAX;
        end
        return v * 64'd10 + d;
    endfunction

    task automatic take_char(input logic [7:0] c);
        logic digit;
        logic unused_sat;
        digit      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        unused_sat = 1'b0;
        if (!bad)
        begin
            case (phase)
                PH_PREFIX:
                begin
                    if (match_pos < PREFIX_LEN && c == UNIT_WORD[8*(5-match_pos) +: 8])
                    begin
                        match_pos++;
                        if (match_pos == PREFIX_LEN)
                            phase = PH_FIRST;
                    end
                    else
                        bad = 1'b1;
                end
                PH_FIRST, PH_START:
                begin
                    if (digit)
                    begin
                        start_acc = decimal_step(start_acc, c, unused_sat);
                        has_start = 1'b1;
                        phase     = PH_START;
                    end
                    else if (c == CHAR_DASH)
                        phase = PH_END;
                    else
                        bad = 1'b1;
                end
                PH_END:
                begin
                    if (digit)
                    begin
                        end_acc = decimal_step(end_acc, c, end_sat);
                        has_end = 1'b1;
                    end
                    else
                        bad = 1'b1;
                end
                default: bad = 1'b1;
            endcase
        end
    endtask

    function automatic byte_range_t predict_range();
        byte_range_t r;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        ok;
        logic [63:0] whole_end;
        logic [63:0] count;
        lo = '0;
        hi = '0;
        ok = !bad && phase == PH_END && start_acc < obj_len;
        if (ok)
        begin
            lo = start_acc;
            if (has_end)
            begin
                if (!has_start)
                begin
                    lo = (end_sat || end_acc >= obj_len) ? 64'd0 : obj_len - end_acc;
                    hi = obj_len - 64'd1;
                end
                else
                    hi = end_acc;
            end
            else
                hi = obj_len - 64'd1;
            if (hi >= obj_len)
                hi = obj_len - 64'd1;
            if (lo > hi)
                ok = 1'b0;
        end
        if (ok)
        begin
            count       = hi - lo + 64'd1;
            r.accepted  = 1'b1;
            r.start_pos = lo[LEN_BITS-1:0];
            r.end_pos   = hi[LEN_BITS-1:0];
            r.span      = count[LEN_BITS-1:0];
        end
        else
        begin
            whole_end   = (obj_len == 64'd0) ? 64'd0 : obj_len - 64'd1;
            r.accepted  = 1'b0;
            r.start_pos = '0;
            r.end_pos   = whole_end[LEN_BITS-1:0];
            r.span      = obj_len[LEN_BITS-1:0];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        byte_range_t want;
        if (!rst_n)
        begin
            obj_len = '0;
            clear_parse();
            expected_ranges.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_ranges.size() == 0)
                begin
                    $error("result item with no header pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_ranges.pop_front();
                    if (range_accepted !== want.accepted)
                    begin
                        $error("range_accepted: expected %0d, got %0d",
                               want.accepted, range_accepted);
                        fail_count++;
                    end
                    if (first_byte !== want.start_pos)
                    begin
                        $error("first_byte: expected %0d, got %0d", want.start_pos, first_byte);
                        fail_count++;
                    end
                    if (last_byte !== want.end_pos)
                    begin
                        $error("last_byte: expected %0d, got %0d", want.end_pos, last_byte);
                        fail_count++;
                    end
                    if (part_length !== want.span)
                    begin
                        $error("part_length: expected %0d, got %0d", want.span, part_length);
                        fail_count++;
                    end
                end
            end
            if (config_we)
                obj_len = 64'(config_data);
            if (in_valid && !in_stall)
            begin
                take_char(header_char);
                if (is_last)
                begin
                    expected_ranges.push_back(predict_range());
                    clear_parse();
                end
            end
            pending = expected_ranges.size();
        end
    end

endmodule

@@ tb/byte_range_header_parser_tb.sv @@
// ---------------------------------------------------------------------------
// Byte range header parser testbench
// Feeds range header values one character per item, first a directed set of
// corner cases and then random headers, mostly well formed, over several
// object lengths. Both channels idle at random; the checker beside the
// block predicts and compares every result.
// ---------------------------------------------------------------------------
module byte_range_header_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import brhp_pkg::*;

    localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;

    typedef logic [7:0] char_q_t[$];

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          header_char = '0;
    logic                is_last = 1'b0;
    logic                config_we = 1'b0;
    logic [LEN_BITS-1:0] config_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                range_accepted;
    logic [LEN_BITS-1:0] first_byte;
    logic [LEN_BITS-1:0] last_byte;
    logic [LEN_BITS-1:0] part_length;
    int                  fail_count;
    int                  pending;

    logic [63:0] cur_len = '0;
    int          chars_sent = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    byte_range_header_parser u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .header_char    (header_char),
        .is_last        (is_last),
        .config_we      (config_we),
        .config_data    (config_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .range_accepted (range_accepted),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .part_length    (part_length)
    );

    byte_range_header_parser_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .header_char    (header_char),
        .is_last        (is_last),
        .config_we      (config_we),
        .config_data    (config_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .range_accepted (range_accepted),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .part_length    (part_length),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] random_len();
        return {$urandom, $urandom} & LEN_MAX;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] pick_pos(input logic [63:0] len);
        int r;
        int k;
        r = $urandom_range(0, 9);
        k = $urandom_range(0, 4);
        case (r)
            0, 1, 2, 3: return $urandom_range(0, 20);
            4, 5:       return (len + k >= 2) ? len + k - 2 : 64'd0;
            6, 7:       return (len == 0) ? 64'd0 : random_len() % len;
            8:          return random_len();
            default:    return $urandom_range(0, 999);
        endcase
    endfunction

    task automatic put_text(ref char_q_t h, input string s);
        for (int i = 0; i < s.len(); i++)
            h.push_back(s[i]);
    endtask

    task automatic put_position(ref char_q_t h);
        int n;
        if ($urandom_range(0, 15) == 0)
        begin
            n = $urandom_range(15, 22);
            repeat (n) h.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        else
            put_text(h, $sformatf("%0d", pick_pos(cur_len)));
    endtask

    task automatic send_item(input logic [7:0] c, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        header_char <= c;
        is_last     <= last;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_header(input char_q_t h);
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        foreach (h[i])
            send_item(h[i], i == h.size() - 1, burst);
    endtask

    task automatic send_text(input string s);
        char_q_t h;
        put_text(h, s);
        send_header(h);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_length(input logic [63:0] v);
        in_valid <= 1'b0;
        wait_idle();
        repeat (8) @(posedge clk);
        config_we   <= 1'b1;
        config_data <= v[LEN_BITS-1:0];
        @(posedge clk);
        config_we <= 1'b0;
        cur_len = v;
    endtask

    task automatic send_random_header();
        char_q_t h;
        int      r;
        int      form;
        int      n;
        r = $urandom_range(0, 99);
        if (r < 85)
        begin
            put_text(h, "bytes=");
            form = $urandom_range(0, 9);
            if (form <= 5)
                put_position(h);
            h.push_back(CHAR_DASH);
            if (form <= 3 || (form >= 6 && form <= 8))
                put_position(h);
            if (r >= 65)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        n = $urandom_range(1, h.size());
                        h = h[0:n-1];
                    end
                    1:       h[$urandom_range(0, h.size() - 1)] = 8'($urandom_range(0, 255));
                    default: h.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n) h.push_back(8'($urandom_range(0, 255)));
        end
        send_header(h);
    endtask

    initial
    begin
        char_q_t     h;
        int          phase_start;
        int          headers;
        logic [63:0] len;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        write_length(64'd1000);
        send_text("bytes=0-99");
        send_text("bytes=500-");
        send_text("bytes=-100");
        send_text("bytes=-2000");
        send_text("bytes=-0");
        send_text("bytes=-");
        send_text("bytes=900-5000");
        send_text("bytes=1000-");
        send_text("bytes=7-3");
        send_text("Bytes=0-1");
        send_text("bytes=12");
        send_text("bytes=1-2x");
        put_text(h, "bytes=5");
        h.push_back(8'h00);
        send_header(h);
        send_text("bytes=99999999999999999999-");
        send_text("bytes=-99999999999999999999");
        send_text("b");
        h = {8'hff};
        send_header(h);

        write_length(64'd0);
        send_text("bytes=0-0");
        send_text("bytes=-");

        write_length(LEN_MAX);
        send_text("bytes=0-");
        send_text("bytes=281474976710654-");
        send_text("bytes=-281474976710655");

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0:       len = 64'd1000;
                1:       len = random_len();
                2:       len = 64'd1;
                3:       len = LEN_MAX;
                4:       len = $urandom_range(2, 50);
                5:       len = 64'd0;
                6:       len = random_len() >> $urandom_range(0, 40);
                default: len = 64'd100000;
            endcase
            write_length(len);
            if (p == 1)
                hold_req = 1'b1;
            phase_start = chars_sent;
            headers = 0;
            while (chars_sent - phase_start < 30 || headers < 2)
            begin
                send_random_header();
                headers++;
            end
        end

        in_valid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[byte_range_header_parser] OK");
        else
            $display("[byte_range_header_parser] ERROR");
        $finish;
    end

    initial
    begin
        int n;
        int m;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                n = $urandom_range(0, 99);
                if (n < 40)
                    n = 0;
                else if (n < 90)
                    n = $urandom_range(1, 3);
                else
                    n = $urandom_range(20, 60);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                m = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
                out_stall <= 1'b0;
                repeat (m) @(posedge clk);
            end
        end
    end

    initial
    begin
        #6ms;
        $display("[byte_range_header_parser] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/brhp_pkg.sv
sv/byte_range_header_parser.sv
sv/brhp_checker.sv
tb/byte_range_header_parser_checker.sv
tb/byte_range_header_parser_tb.sv
